### sv/jsu_pkg.sv
package jsu_pkg;

    // Input selector codes
    localparam logic [1:0] FN_BYTE  = 2'd0;
    localparam logic [1:0] FN_END   = 2'd1;
    localparam logic [1:0] FN_START = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_DONE         = 4'd1;
    localparam logic [3:0] ST_UNTERM       = 4'd2;
    localparam logic [3:0] ST_CTRL         = 4'd3;
    localparam logic [3:0] ST_UNTERM_ESC   = 4'd4;
    localparam logic [3:0] ST_UNK_ESC      = 4'd5;
    localparam logic [3:0] ST_TRUNC_HEX    = 4'd6;
    localparam logic [3:0] ST_BAD_HEX      = 4'd7;
    localparam logic [3:0] ST_HIGH_NO_LOW  = 4'd8;
    localparam logic [3:0] ST_HIGH_NON_LOW = 4'd9;
    localparam logic [3:0] ST_LONE_LOW     = 4'd10;

    // Decoder modes, one-hot
    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_DONE    = 9'b000000010,
        M_ERROR   = 9'b000000100,
        M_TEXT    = 9'b000001000,
        M_ESC     = 9'b000010000,
        M_HEX1    = 9'b000100000,
        M_WANT_BS = 9'b001000000,
        M_WANT_U  = 9'b010000000,
        M_HEX2    = 9'b100000000
    } t_mode;

    // All results caused by one input item
    typedef struct packed {
        logic [1:0]      last_idx;
        logic            vld;
        logic [3:0][7:0] bytes;
        logic [3:0]      status;
    } t_group;

    // Hex digit value; bit 4 flags a character that is no hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // UTF-8 bytes of one code point
    function automatic t_group utf8_group(input logic [20:0] cp);
        t_group g;
        g = '0;
        g.vld = 1'b1;
        g.status = ST_OK;
        if (cp < 21'h80) begin
            g.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            g.last_idx = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            g.last_idx = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            g.last_idx = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

endpackage

### sv/jsu_if.sv
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] in_byte;
    modport source (output valid, func, in_byte, input ready);
    modport sink (input valid, func, in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last;
    logic [3:0] status;
    modport source (output valid, out_byte, out_valid, last, status, input ready);
    modport sink (input valid, out_byte, out_valid, last, status, output ready);
endinterface

### sv/json_string_unescape_utf8.sv
// JSON string body decoder.
// Input channel i_in: one word per item; func selects a text byte (in_byte),
// the end of the text, or the start of a new string. Output channel o_out
// gives the decoded words: out_byte with out_valid, a status code and last
// on the final word that an input item causes. Each item gives one word,
// except a completed \u escape, which gives the 1 to 4 UTF-8 bytes.
// The first word of an item passes through the input word register and then
// the result group register to o_out; the group register is loaded only once
// the words of the group before it have been taken.
// Throughput: one item per cycle while each item gives a single word and
// the receiver does not stall; an item that gives more words holds the output
// side until the sequencer has given them all, one word per ready cycle.
// Reset (synchronous, active low) empties both registers and puts the
// decoder in the idle mode, where bytes are ignored until a start item.
// When the receiver stalls, the current word holds; one further item is
// taken into the input register if it is empty, after which i_in.ready falls.
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    logic            grp_valid;
    jsu_pkg::t_group grp;
    logic            take;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_take      (take),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    jsu_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_take      (take),
        .o_out       (o_out)
    );

endmodule

### sv/jsu_decode.sv
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu_in_if.sink           i_in,
    input  logic             i_take,
    output logic             o_grp_valid,
    output jsu_pkg::t_group  o_grp
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic            r_in_v;
    logic [1:0]      r_func;
    logic [7:0]      r_byte;
    jsu_pkg::t_mode  r_mode, n_mode;
    logic [3:0]      r_err, n_err;
    logic [15:0]     r_acc, n_acc;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_bad, n_bad;
    logic [9:0]      r_hi, n_hi;

    logic            fire;
    logic [3:0]      cur_status;
    logic [4:0]      nib;
    logic [15:0]     acc_sh;
    logic            bad_all;
    logic            quad_done;
    logic [20:0]     pair_cp;
    logic            f_fail;
    logic [3:0]      f_code;
    jsu_pkg::t_group grp;

    // Input word register
    assign fire = r_in_v & i_take;
    assign i_in.ready = ~r_in_v | i_take;
    assign o_grp_valid = r_in_v;
    assign o_grp = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_byte <= i_in.in_byte;
        end
    end

    // Shared quad digit path
    assign nib = jsu_pkg::hex_nibble(r_byte);
    assign acc_sh = {r_acc[11:0], nib[3:0]};
    assign bad_all = r_bad | nib[4];
    assign quad_done = (r_cnt == 2'd3);
    assign pair_cp = 21'h10000 + {1'b0, r_hi, acc_sh[9:0]};

    always_comb begin
        if (r_mode == jsu_pkg::M_ERROR) begin
            cur_status = r_err;
        end else if (r_mode == jsu_pkg::M_DONE) begin
            cur_status = jsu_pkg::ST_DONE;
        end else begin
            cur_status = jsu_pkg::ST_OK;
        end
    end

    // Next state and result group
    always_comb begin
        n_mode = r_mode;
        n_err  = r_err;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_bad  = r_bad;
        n_hi   = r_hi;
        f_fail = 1'b0;
        f_code = jsu_pkg::ST_OK;
        grp = '0;
        grp.status = cur_status;
        case (r_func)
            jsu_pkg::FN_BYTE: begin
                case (r_mode)
                    jsu_pkg::M_TEXT: begin
                        if (r_byte == CH_QUOTE) begin
                            n_mode = jsu_pkg::M_DONE;
                            grp.status = jsu_pkg::ST_DONE;
                        end else if (r_byte < CH_SPACE) begin
                            f_fail = 1'b1;
                            f_code = jsu_pkg::ST_CTRL;
                        end else if (r_byte == CH_BSL) begin
                            n_mode = jsu_pkg::M_ESC;
                            grp.status = jsu_pkg::ST_OK;
                        end else begin
                            grp.vld = 1'b1;
                            grp.bytes[0] = r_byte;
                            grp.status = jsu_pkg::ST_OK;
                        end
                    end
                    jsu_pkg::M_ESC: begin
                        n_mode = jsu_pkg::M_TEXT;
                        grp.status = jsu_pkg::ST_OK;
                        grp.vld = 1'b1;
                        case (r_byte)
                            CH_QUOTE, CH_BSL, CH_SLASH: grp.bytes[0] = r_byte;
                            CH_B: grp.bytes[0] = 8'h08;
                            CH_F: grp.bytes[0] = 8'h0C;
                            CH_N: grp.bytes[0] = 8'h0A;
                            CH_R: grp.bytes[0] = 8'h0D;
                            CH_T: grp.bytes[0] = 8'h09;
                            CH_U: begin
                                grp.vld = 1'b0;
                                n_mode = jsu_pkg::M_HEX1;
                                n_acc = '0;
                                n_cnt = '0;
                                n_bad = 1'b0;
                            end
                            default: begin
                                f_fail = 1'b1;
                                f_code = jsu_pkg::ST_UNK_ESC;
                            end
                        endcase
                    end
                    jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
                        n_acc = acc_sh;
                        n_bad = bad_all;
                        n_cnt = r_cnt + 2'd1;
                        grp.status = jsu_pkg::ST_OK;
                        if (quad_done) begin
                            if (bad_all) begin
                                f_fail = 1'b1;
                                f_code = jsu_pkg::ST_BAD_HEX;
                            end else if (r_mode == jsu_pkg::M_HEX1) begin
                                if (acc_sh inside {[16'hD800:16'hDBFF]}) begin
                                    n_hi = acc_sh[9:0];
                                    n_mode = jsu_pkg::M_WANT_BS;
                                end else if (acc_sh inside {[16'hDC00:16'hDFFF]}) begin
                                    f_fail = 1'b1;
                                    f_code = jsu_pkg::ST_LONE_LOW;
                                end else begin
                                    n_mode = jsu_pkg::M_TEXT;
                                    grp = jsu_pkg::utf8_group({5'd0, acc_sh});
                                end
                            end else begin
                                if (acc_sh inside {[16'hDC00:16'hDFFF]}) begin
                                    n_mode = jsu_pkg::M_TEXT;
                                    grp = jsu_pkg::utf8_group(pair_cp);
                                end else begin
                                    f_fail = 1'b1;
                                    f_code = jsu_pkg::ST_HIGH_NON_LOW;
                                end
                            end
                        end
                    end
                    jsu_pkg::M_WANT_BS: begin
                        if (r_byte == CH_BSL) begin
                            n_mode = jsu_pkg::M_WANT_U;
                        end else begin
                            f_fail = 1'b1;
                            f_code = jsu_pkg::ST_HIGH_NO_LOW;
                        end
                    end
                    jsu_pkg::M_WANT_U: begin
                        if (r_byte == CH_U) begin
                            n_mode = jsu_pkg::M_HEX2;
                            n_acc = '0;
                            n_cnt = '0;
                            n_bad = 1'b0;
                        end else begin
                            f_fail = 1'b1;
                            f_code = jsu_pkg::ST_HIGH_NO_LOW;
                        end
                    end
                    default: begin
                        grp.status = cur_status;
                    end
                endcase
            end
            jsu_pkg::FN_END: begin
                case (r_mode)
                    jsu_pkg::M_TEXT: begin
                        f_fail = 1'b1;
                        f_code = jsu_pkg::ST_UNTERM;
                    end
                    jsu_pkg::M_ESC: begin
                        f_fail = 1'b1;
                        f_code = jsu_pkg::ST_UNTERM_ESC;
                    end
                    jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
                        f_fail = 1'b1;
                        f_code = jsu_pkg::ST_TRUNC_HEX;
                    end
                    jsu_pkg::M_WANT_BS, jsu_pkg::M_WANT_U: begin
                        f_fail = 1'b1;
                        f_code = jsu_pkg::ST_HIGH_NO_LOW;
                    end
                    default: begin
                        grp.status = cur_status;
                    end
                endcase
            end
            jsu_pkg::FN_START: begin
                n_mode = jsu_pkg::M_TEXT;
                n_err  = jsu_pkg::ST_OK;
                n_acc  = '0;
                n_cnt  = '0;
                n_bad  = 1'b0;
                n_hi   = '0;
                grp.status = jsu_pkg::ST_OK;
            end
            default: begin
                grp.status = cur_status;
            end
        endcase
        // Enter the sticky error
        if (f_fail) begin
            n_mode = jsu_pkg::M_ERROR;
            n_err = f_code;
            grp = '0;
            grp.status = f_code;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::M_IDLE;
            r_err  <= jsu_pkg::ST_OK;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_bad  <= 1'b0;
            r_hi   <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_err  <= n_err;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_bad  <= n_bad;
            r_hi   <= n_hi;
        end
    end

`ifndef SYNTHESIS
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::M_ERROR) |-> (r_err != jsu_pkg::ST_OK && r_err != jsu_pkg::ST_DONE))
        else $error("error mode without an error code");
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !i_take) |=> (r_in_v && $stable(r_func) && $stable(r_byte)))
        else $error("waiting input word lost");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_func == jsu_pkg::FN_START) |=> (r_mode == jsu_pkg::M_TEXT && r_cnt == 2'd0))
        else $error("start did not enter text mode");
    a_fail_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && f_fail) |-> (!grp.vld && grp.last_idx == 2'd0))
        else $error("error result carries data");
`endif

endmodule

### sv/jsu_emit.sv
module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_grp_valid,
    input  jsu_pkg::t_group  i_grp,
    output logic             o_take,
    jsu_out_if.source        o_out
);

    jsu_pkg::t_group r_grp;
    logic            r_full;
    logic [1:0]      r_idx;
    logic            beat_last;
    logic            beat_go;

    assign beat_last = (r_idx == r_grp.last_idx);
    assign beat_go   = r_full & o_out.ready;
    assign o_take    = ~r_full | (beat_go & beat_last);

    // Present the current word of the group
    assign o_out.valid     = r_full;
    assign o_out.out_byte  = r_grp.bytes[r_idx];
    assign o_out.out_valid = r_grp.vld;
    assign o_out.last      = beat_last;
    assign o_out.status    = r_grp.status;

    // Load a new group, or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (o_take) begin
            r_full <= i_grp_valid;
            r_idx  <= '0;
        end else if (beat_go) begin
            r_idx <= r_idx + 2'd1;
        end
        if (o_take && i_grp_valid) begin
            r_grp <= i_grp;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_idx <= r_grp.last_idx))
        else $error("word index beyond group");
    a_multi_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_grp.last_idx != 2'd0) |-> (r_grp.vld && r_grp.status == jsu_pkg::ST_OK))
        else $error("multi-word group without data");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat_go && !beat_last) |=> (r_full && r_idx == $past(r_idx) + 2'd1))
        else $error("group did not advance");
`endif

endmodule

### verif/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    // Selector value that the block does not use
    localparam logic [1:0] FN_SPARE = 2'd3;

    // Characters with a meaning to the decoder
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One output word as seen on the result channel
    typedef struct packed {
        logic [7:0] data;
        logic       data_vld;
        logic       last;
        logic [3:0] status;
    } t_out_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Decoder state mirrored by the testbench
    t_mode       dec_mode      = M_IDLE;
    logic [15:0] quad_value    = '0;
    logic [1:0]  quad_count    = '0;
    logic        quad_bad      = 1'b0;
    logic [9:0]  high_bits     = '0;
    logic [3:0]  sticky_status = ST_OK;

    t_out_word expected_words[$];
    t_out_word item_words[$];

    int mismatch_count = 0;
    int items_decoded  = 0;
    int send_gap_pct   = 12;
    int recv_stall_pct = 65;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic logic [4:0] hex_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void add_word(logic [7:0] d, logic v, logic [3:0] s);
        t_out_word w;
        w.data     = v ? d : 8'h00;
        w.data_vld = v;
        w.last     = 1'b0;
        w.status   = s;
        item_words = {item_words, w};
    endfunction

    function automatic void raise_error(logic [3:0] code);
        dec_mode      = M_ERROR;
        sticky_status = code;
        add_word(8'h00, 1'b0, code);
    endfunction

    function automatic logic [3:0] status_now();
        if (dec_mode == M_ERROR) return sticky_status;
        if (dec_mode == M_DONE) return ST_DONE;
        return ST_OK;
    endfunction

    function automatic void encode_utf8(logic [20:0] cp);
        if (cp < 21'h80) begin
            add_word(cp[7:0], 1'b1, ST_OK);
        end else if (cp < 21'h800) begin
            add_word(8'hC0 | cp[10:6], 1'b1, ST_OK);
            add_word(8'h80 | cp[5:0], 1'b1, ST_OK);
        end else if (cp < 21'h10000) begin
            add_word(8'hE0 | cp[15:12], 1'b1, ST_OK);
            add_word(8'h80 | cp[11:6], 1'b1, ST_OK);
            add_word(8'h80 | cp[5:0], 1'b1, ST_OK);
        end else begin
            add_word(8'hF0 | cp[20:18], 1'b1, ST_OK);
            add_word(8'h80 | cp[17:12], 1'b1, ST_OK);
            add_word(8'h80 | cp[11:6], 1'b1, ST_OK);
            add_word(8'h80 | cp[5:0], 1'b1, ST_OK);
        end
    endfunction

    function automatic void open_quad(t_mode m);
        dec_mode   = m;
        quad_value = '0;
        quad_count = '0;
        quad_bad   = 1'b0;
    endfunction

    // Shift in one quad character; true once the fourth has come
    function automatic logic take_quad_char(logic [7:0] c);
        logic [4:0] nib;
        nib = hex_value(c);
        if (nib[4]) quad_bad = 1'b1;
        quad_value = {quad_value[11:0], nib[3:0]};
        if (quad_count == 2'd3) begin
            quad_count = 2'd0;
            return 1'b1;
        end
        quad_count = quad_count + 2'd1;
        return 1'b0;
    endfunction

    function automatic void decode_text_byte(logic [7:0] c);
        case (dec_mode)
            M_TEXT: begin
                if (c == CH_QUOTE) begin
                    dec_mode = M_DONE;
                    add_word(8'h00, 1'b0, ST_DONE);
                end else if (c < CH_SPACE) begin
                    raise_error(ST_CTRL);
                end else if (c == CH_BSLASH) begin
                    dec_mode = M_ESC;
                    add_word(8'h00, 1'b0, ST_OK);
                end else begin
                    add_word(c, 1'b1, ST_OK);
                end
            end
            M_ESC: begin
                dec_mode = M_TEXT;
                case (c)
                    CH_QUOTE, CH_BSLASH, 8'h2F: add_word(c, 1'b1, ST_OK);
                    8'h62: add_word(8'h08, 1'b1, ST_OK);   // b
                    8'h66: add_word(8'h0C, 1'b1, ST_OK);   // f
                    8'h6E: add_word(8'h0A, 1'b1, ST_OK);   // n
                    8'h72: add_word(8'h0D, 1'b1, ST_OK);   // r
                    8'h74: add_word(8'h09, 1'b1, ST_OK);   // t
                    CH_U: begin
                        open_quad(M_HEX1);
                        add_word(8'h00, 1'b0, ST_OK);
                    end
                    default: raise_error(ST_UNK_ESC);
                endcase
            end
            M_HEX1: begin
                if (!take_quad_char(c)) begin
                    add_word(8'h00, 1'b0, ST_OK);
                end else if (quad_bad) begin
                    raise_error(ST_BAD_HEX);
                end else if (quad_value >= 16'hD800 && quad_value <= 16'hDBFF) begin
                    high_bits = quad_value[9:0];
                    dec_mode  = M_WANT_BS;
                    add_word(8'h00, 1'b0, ST_OK);
                end else if (quad_value >= 16'hDC00 && quad_value <= 16'hDFFF) begin
                    raise_error(ST_LONE_LOW);
                end else begin
                    dec_mode = M_TEXT;
                    encode_utf8({5'd0, quad_value});
                end
            end
            M_WANT_BS: begin
                if (c == CH_BSLASH) begin
                    dec_mode = M_WANT_U;
                    add_word(8'h00, 1'b0, ST_OK);
                end else begin
                    raise_error(ST_HIGH_NO_LOW);
                end
            end
            M_WANT_U: begin
                if (c == CH_U) begin
                    open_quad(M_HEX2);
                    add_word(8'h00, 1'b0, ST_OK);
                end else begin
                    raise_error(ST_HIGH_NO_LOW);
                end
            end
            M_HEX2: begin
                if (!take_quad_char(c)) begin
                    add_word(8'h00, 1'b0, ST_OK);
                end else if (quad_bad) begin
                    raise_error(ST_BAD_HEX);
                end else if (quad_value < 16'hDC00 || quad_value > 16'hDFFF) begin
                    raise_error(ST_HIGH_NON_LOW);
                end else begin
                    dec_mode = M_TEXT;
                    encode_utf8(21'h10000 + {1'b0, high_bits, quad_value[9:0]});
                end
            end
            default: add_word(8'h00, 1'b0, status_now());
        endcase
    endfunction

    function automatic void decode_end();
        case (dec_mode)
            M_TEXT:              raise_error(ST_UNTERM);
            M_ESC:               raise_error(ST_UNTERM_ESC);
            M_HEX1, M_HEX2:      raise_error(ST_TRUNC_HEX);
            M_WANT_BS, M_WANT_U: raise_error(ST_HIGH_NO_LOW);
            default:             add_word(8'h00, 1'b0, status_now());
        endcase
    endfunction

    // Queue the words one accepted item causes; true if the item is ignored
    function automatic logic predict_decode(logic [1:0] f, logic [7:0] b);
        t_out_word w;
        logic      ignored;
        ignored = (f != FN_START) &&
                  (dec_mode == M_IDLE || dec_mode == M_DONE || dec_mode == M_ERROR);
        item_words.delete();
        case (f)
            FN_BYTE: decode_text_byte(b);
            FN_END:  decode_end();
            FN_START: begin
                open_quad(M_TEXT);
                high_bits     = '0;
                sticky_status = ST_OK;
                add_word(8'h00, 1'b0, ST_OK);
            end
            default: add_word(8'h00, 1'b0, status_now());
        endcase
        w = item_words.pop_back();
        w.last = 1'b1;
        item_words = {item_words, w};
        expected_words = {expected_words, item_words};
        return ignored;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, t_out_word want, t_out_word got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected byte=%h vld=%b last=%b status=%0d, ",
                      "got byte=%h vld=%b last=%b status=%0d"},
                     $realtime, what, want.data, want.data_vld, want.last, want.status,
                     got.data, got.data_vld, got.last, got.status);
    endtask

    task automatic check_word();
        t_out_word want;
        t_out_word got;
        got = {out_if.out_byte, out_if.out_valid, out_if.last, out_if.status};
        if (expected_words.size() == 0) begin
            report_mismatch("word with nothing pending", '0, got);
        end else begin
            want = expected_words.pop_front();
            if (got !== want) report_mismatch("word mismatch", want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            check_word();
    end

    // Stall the receiver at random
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word, with random gaps first; returns at the falling edge
    task automatic send_word(logic [1:0] f, logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.func    <= f;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (!predict_decode(f, b)) items_decoded++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(FN_BYTE, s[i]);
    endtask

    // Hold the sender until every pending word has come out
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] v;
        do begin
            b = 8'($urandom_range(255));
            v = hex_value(b);
        end while (!v[4]);
        return b;
    endfunction

    // Send \u and up to four quad characters; one may be spoilt
    task automatic send_quad(logic [15:0] v, int n_chars, int bad_pos);
        send_word(FN_BYTE, CH_BSLASH);
        send_word(FN_BYTE, CH_U);
        for (int i = 0; i < n_chars; i++)
            send_word(FN_BYTE, (i == bad_pos) ? non_hex_byte() : hex_char(v[15 - 4 * i -: 4]));
    endtask

    task automatic send_unicode();
        logic [15:0] v;
        case ($urandom_range(3))
            0: send_quad(16'($urandom_range(16'h7F)), 4, 4);
            1: send_quad(16'($urandom_range(16'h7FF, 16'h80)), 4, 4);
            2: begin
                v = 16'($urandom_range(16'hFFFF, 16'h800));
                if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h2000;
                send_quad(v, 4, 4);
            end
            default: begin
                send_quad(16'($urandom_range(16'hDBFF, 16'hD800)), 4, 4);
                send_quad(16'($urandom_range(16'hDFFF, 16'hDC00)), 4, 4);
            end
        endcase
    endtask

    // Malformed or out-of-place input
    task automatic send_noise();
        logic [15:0] high;
        high = 16'($urandom_range(16'hDBFF, 16'hD800));
        case ($urandom_range(9))
            0: send_word(FN_BYTE, 8'($urandom_range(255)));
            1: send_word(FN_BYTE, 8'($urandom_range(8'h1F)));
            2: send_word(FN_END, 8'($urandom_range(255)));
            3: send_word(FN_SPARE, 8'($urandom_range(255)));
            4: begin
                send_word(FN_BYTE, CH_BSLASH);
                send_word(FN_BYTE, 8'($urandom_range(255)));
            end
            5: send_quad(16'($urandom), 4, $urandom_range(3));
            6: begin
                send_quad(16'($urandom), $urandom_range(3), $urandom_range(4));
                send_word(FN_END, 8'($urandom_range(255)));
            end
            7: send_quad(16'($urandom_range(16'hDFFF, 16'hDC00)), 4, 4);
            8: begin
                // high surrogate followed by a stray byte, a bad escape, an end or a random quad
                send_quad(high, 4, 4);
                case ($urandom_range(4))
                    0: send_word(FN_BYTE, 8'($urandom_range(255)));
                    1: begin
                        send_word(FN_BYTE, CH_BSLASH);
                        send_word(FN_BYTE, 8'($urandom_range(255)));
                    end
                    2: begin
                        send_word(FN_BYTE, CH_BSLASH);
                        send_word(FN_END, 8'($urandom_range(255)));
                    end
                    3: send_word(FN_END, 8'($urandom_range(255)));
                    default: send_quad(16'($urandom), 4, 4);
                endcase
            end
            default: begin
                send_quad(high, 4, 4);
                send_quad(16'($urandom_range(16'hDFFF, 16'hDC00)), 4, $urandom_range(3));
            end
        endcase
    endtask

    task automatic send_random_string();
        logic [7:0] escapes[8];
        int         kind;
        escapes = '{CH_QUOTE, CH_BSLASH, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
        if ($urandom_range(9) != 0) send_word(FN_START, 8'($urandom_range(255)));
        repeat ($urandom_range(6, 1)) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                send_word(FN_BYTE, 8'($urandom_range(8'hFF, 8'h20)));
            end else if (kind < 55) begin
                send_word(FN_BYTE, CH_BSLASH);
                send_word(FN_BYTE, escapes[3'($urandom_range(7))]);
            end else if (kind < 85) begin
                send_unicode();
            end else begin
                send_noise();
            end
        end
        if ($urandom_range(9) < 8) send_word(FN_BYTE, CH_QUOTE);
        else send_word(FN_END, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes, ends and the spare selector before any start
    task automatic test_idle_input();
        send_word(FN_BYTE, 8'h00);
        send_word(FN_END, 8'hFF);
        send_word(FN_SPARE, 8'hAA);
    endtask

    // Extreme plain bytes, a 3-byte escape, done and error stickiness
    task automatic test_plain_extremes();
        send_word(FN_START, 8'h00);
        send_word(FN_BYTE, CH_SPACE);
        send_word(FN_BYTE, 8'hFF);
        send_word(FN_BYTE, 8'h7F);
        send_text("\\\"\\uFFFF\\u0000\"");
        send_word(FN_BYTE, 8'h41);
        send_word(FN_SPARE, 8'h55);
        send_word(FN_END, 8'h00);
        send_word(FN_START, 8'hFF);
        send_word(FN_BYTE, 8'h1F);
        send_word(FN_BYTE, 8'h00);
    endtask

    // Surrogate pairs at both ends of the range and one between
    task automatic test_surrogate_pair();
        send_word(FN_START, 8'h00);
        send_text("\\uD83D\\uDE00\\udbff\\udfff\\ud800\\udc00\"");
    endtask

    task automatic test_random_text(int gap_pct, int stall_pct, int goal);
        hold_until_drained();
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        goal = items_decoded + goal;
        while (items_decoded < goal) send_random_string();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.func    = FN_BYTE;
        in_if.in_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_input();
        test_plain_extremes();
        test_surrogate_pair();
        test_random_text(12, 65, 20);
        test_random_text(65, 12, 20);
        test_random_text(0, 0, 20);

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("json_string_unescape_utf8_test passed");
        end else begin
            $display("json_string_unescape_utf8_test failed");
        end
        $finish;
    end

    // Bound the run in case the block hangs
    initial begin
        #2_000_000;
        $display("json_string_unescape_utf8_test failed");
        $finish;
    end

endmodule

### files.f
sv/jsu_pkg.sv
sv/jsu_if.sv
sv/jsu_decode.sv
sv/jsu_emit.sv
sv/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_test.sv
